[rtl/gdad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gdad_pkg;

  // year mod 400 travels with the date so leap checks need no divider
  localparam int unsigned R400_W = 9;
  localparam logic [R400_W-1:0] LAST_R400 = 9'd399;
  localparam logic [R400_W-1:0] CENT_1 = 9'd100;
  localparam logic [R400_W-1:0] CENT_2 = 9'd200;
  localparam logic [R400_W-1:0] CENT_3 = 9'd300;

  localparam logic [3:0] MONTH_NONE = 4'd0;
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_MAY = 4'd5;
  localparam logic [3:0] MONTH_JUL = 4'd7;
  localparam logic [3:0] MONTH_AUG = 4'd8;
  localparam logic [3:0] MONTH_OCT = 4'd10;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] LEN_LEAP_FEB = 5'd29;
  localparam logic [4:0] LEN_FEB = 5'd28;
  localparam logic [4:0] LEN_LONG = 5'd31;
  localparam logic [4:0] LEN_SHORT = 5'd30;

  typedef enum logic [1:0] {
    F_IDLE,
    F_REDUCE,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } back_state_t;

  // fixed-width part of a queued request
  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [R400_W-1:0] r400;
    logic              invalid;
  } date_fix_t;

  function automatic logic leap_from_r400(input logic [R400_W-1:0] r);
    logic leap;
    leap = (r == '0) ||
           ((r[1:0] == 2'b00) && (r != CENT_1) && (r != CENT_2) && (r != CENT_3));
    return leap;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_FEB: len = leap ? LEN_LEAP_FEB : LEN_FEB;
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL, MONTH_AUG, MONTH_OCT, MONTH_DEC:
        len = LEN_LONG;
      default: len = LEN_SHORT;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[rtl/gdad_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface gdad_in_if #(
  parameter int YEAR_BITS = 16,
  parameter int OFFSET_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [4:0]             start_day;
  logic [3:0]             start_month;
  logic [YEAR_BITS-1:0]   start_year;
  logic [OFFSET_BITS-1:0] day_offset;

  modport source (output valid, start_day, start_month, start_year, day_offset,
                  input ready);
  modport sink (input valid, start_day, start_month, start_year, day_offset,
                output ready);
endinterface

interface gdad_out_if #(
  parameter int YEAR_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [4:0]           result_day;
  logic [3:0]           result_month;
  logic [YEAR_BITS-1:0] result_year;
  logic                 input_invalid;
  logic                 year_overflow;

  modport source (output valid, result_day, result_month, result_year, input_invalid,
                  year_overflow, input ready);
  modport sink (input valid, result_day, result_month, result_year, input_invalid,
                year_overflow, output ready);
endinterface
`default_nettype wire

[rtl/gregorian_date_add_days.sv]
`timescale 1ns / 1ps
`default_nettype none
// Front end: states IDLE, REDUCE (year mod 400 by reciprocal multiply) and PUSH (range check).
// Back end: steps M months per request, M = months crossed, one month per cycle;
//   worst case about 2160 months at OFFSET_BITS = 16.
// The front end can accept a new request while the back end works on an earlier one,
//   with a two-entry queue between the halves.
// Reset (synchronous): both state machines idle, queue empty, no result pending.
module gregorian_date_add_days #(
  parameter int YEAR_BITS = 16,
  parameter int OFFSET_BITS = 16
) (
  input  wire        clk,
  input  wire        rst,
  gdad_in_if.sink    req,
  gdad_out_if.source rsp
);

  localparam int DATA_W = $bits(gdad_pkg::date_fix_t) + YEAR_BITS + OFFSET_BITS;

  logic              push_valid;
  logic              push_ready;
  logic [DATA_W-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [DATA_W-1:0] pop_data;

  gdad_front #(
    .YEAR_BITS(YEAR_BITS),
    .OFFSET_BITS(OFFSET_BITS),
    .DATA_W(DATA_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .req(req),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data(push_data)
  );

  gdad_queue #(
    .DATA_W(DATA_W),
    .DEPTH(2)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data(push_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data(pop_data)
  );

  gdad_back #(
    .YEAR_BITS(YEAR_BITS),
    .OFFSET_BITS(OFFSET_BITS),
    .DATA_W(DATA_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data(pop_data),
    .rsp(rsp)
  );

endmodule
`default_nettype wire

[rtl/gdad_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module gdad_front #(
  parameter int YEAR_BITS = 16,
  parameter int OFFSET_BITS = 16,
  parameter int DATA_W = 50
) (
  input  wire              clk,
  input  wire              rst,
  gdad_in_if.sink          req,
  output logic             push_valid,
  input  wire              push_ready,
  output logic [DATA_W-1:0] push_data
);

  localparam int R_W = gdad_pkg::R400_W;
  // year mod 400 = 16 * ((year >> 4) mod 25) + (year mod 16)
  localparam int X_W = YEAR_BITS - 4;
  localparam int SH = X_W + 5;
  localparam int RECIP_W = X_W + 1;
  localparam int PROD_W = X_W + RECIP_W;
  localparam int Q_W = PROD_W - SH;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'd24) / 64'd25;

  gdad_pkg::front_state_t state, state_next;

  logic [4:0]             day;
  logic [3:0]             month;
  logic [YEAR_BITS-1:0]   year;
  logic [OFFSET_BITS-1:0] add;
  logic [Q_W-1:0]         quot;

  logic [PROD_W-1:0]      prod;
  logic [4:0]             quot5;
  logic [9:0]             quot25;
  logic [4:0]             r25;
  logic [R_W-1:0]         r400;
  logic [4:0]             len;
  gdad_pkg::date_fix_t    fix;

  // (year >> 4) / 25 by reciprocal multiply, exact over the whole input range
  always_comb begin
    prod = PROD_W'(year[YEAR_BITS-1:4]) * PROD_W'(RECIP[RECIP_W-1:0]);
  end

  // remainder is below 25, so five low bits of x - 25q are enough
  always_comb begin
    quot5 = 5'(quot);
    quot25 = {1'b0, quot5, 4'b0000} + {2'b00, quot5, 3'b000} + {5'b00000, quot5};
    r25 = year[8:4] - quot25[4:0];
    r400 = {r25, year[3:0]};
  end

  always_comb begin
    len = gdad_pkg::month_len(month, gdad_pkg::leap_from_r400(r400));
    fix.day = day;
    fix.month = month;
    fix.r400 = r400;
    fix.invalid = (day == 5'd0) || (day > len) || (month == gdad_pkg::MONTH_NONE) ||
                  (month > gdad_pkg::MONTH_DEC);
    push_data = {fix, year, add};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdad_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready = 1'b0;
    push_valid = 1'b0;
    case (state)
      gdad_pkg::F_IDLE: begin
        req.ready = !rst;
        if (req.valid && !rst) state_next = gdad_pkg::F_REDUCE;
      end
      gdad_pkg::F_REDUCE: begin
        state_next = gdad_pkg::F_PUSH;
      end
      gdad_pkg::F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) state_next = gdad_pkg::F_IDLE;
      end
      default: state_next = gdad_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      gdad_pkg::F_IDLE: begin
        if (req.valid && req.ready) begin
          day <= req.start_day;
          month <= req.start_month;
          year <= req.start_year;
          add <= req.day_offset;
        end
      end
      gdad_pkg::F_REDUCE: begin
        quot <= prod[PROD_W-1:SH];
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/gdad_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module gdad_queue #(
  parameter int DATA_W = 50,
  parameter int DEPTH = 2
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push_valid,
  output logic              push_ready,
  input  wire  [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  wire               pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/gdad_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module gdad_back #(
  parameter int YEAR_BITS = 16,
  parameter int OFFSET_BITS = 16,
  parameter int DATA_W = 50
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               pop_valid,
  output logic              pop_ready,
  input  wire  [DATA_W-1:0] pop_data,
  gdad_out_if.source        rsp
);

  localparam int DAY_W = OFFSET_BITS + 1;
  localparam int R_W = gdad_pkg::R400_W;

  gdad_pkg::back_state_t state, state_next;

  gdad_pkg::date_fix_t    in_fix;
  logic [YEAR_BITS-1:0]   in_year;
  logic [OFFSET_BITS-1:0] in_add;

  logic [DAY_W-1:0]     day_acc;
  logic [3:0]           month;
  logic [YEAR_BITS-1:0] year;
  logic [R_W-1:0]       r400;
  logic                 invalid;
  logic                 wrapped;

  logic                 out_valid;
  logic                 out_load;
  logic [4:0]           len;
  logic                 step;

  assign {in_fix, in_year, in_add} = pop_data;

  assign len = gdad_pkg::month_len(month, gdad_pkg::leap_from_r400(r400));
  assign step = day_acc > {{(DAY_W-5){1'b0}}, len};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdad_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      gdad_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) state_next = gdad_pkg::B_RUN;
      end
      gdad_pkg::B_RUN: begin
        if (!step) state_next = gdad_pkg::B_DONE;
      end
      gdad_pkg::B_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load = 1'b1;
          state_next = gdad_pkg::B_IDLE;
        end
      end
      default: state_next = gdad_pkg::B_IDLE;
    endcase
  end

  // one month per cycle
  always_ff @(posedge clk) begin
    case (state)
      gdad_pkg::B_IDLE: begin
        if (pop_valid) begin
          day_acc <= {{(DAY_W-5){1'b0}}, in_fix.day} + {1'b0, in_add};
          month <= in_fix.month;
          year <= in_year;
          r400 <= in_fix.r400;
          invalid <= in_fix.invalid;
          wrapped <= 1'b0;
        end
      end
      gdad_pkg::B_RUN: begin
        if (step) begin
          day_acc <= day_acc - {{(DAY_W-5){1'b0}}, len};
          if (month >= gdad_pkg::MONTH_DEC) begin
            month <= gdad_pkg::MONTH_JAN;
            if (year == '1) begin
              year <= '0;
              r400 <= '0;
              wrapped <= 1'b1;
            end else begin
              year <= year + {{(YEAR_BITS-1){1'b0}}, 1'b1};
              r400 <= (r400 == gdad_pkg::LAST_R400) ? '0 : r400 + R_W'(1);
            end
          end else begin
            month <= month + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.result_day <= day_acc[4:0];
      rsp.result_month <= month;
      rsp.result_year <= year;
      rsp.input_invalid <= invalid;
      rsp.year_overflow <= wrapped;
    end
  end

  assign rsp.valid = out_valid;

endmodule
`default_nettype wire
